[rtl/fps_pkg.sv]
package fps_pkg;

  // Largest number of frames the sequencer can address.
  localparam int MaxFrames = 64;
  localparam int FrameW    = $clog2(MaxFrames);
  localparam int CountW    = 7;
  localparam int MaskW     = 64;
  localparam int KindW     = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  typedef enum logic [KindW-1:0] {
    KindTick     = 3'd0,
    KindStepFwd  = 3'd1,
    KindStepBack = 3'd2,
    KindGoto     = 3'd3,
    KindPlay     = 3'd4,
    KindStop     = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameCount = 3'd0,
    RegRangeMode  = 3'd1,
    RegBounceMode = 3'd2,
    RegOnceMode   = 3'd3,
    RegSelMask    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [FrameW-1:0] target_frame;
  } cmd_t;

  typedef struct packed {
    logic [FrameW-1:0] current_frame;
    logic              frame_shown;
    logic              is_playing;
    logic              forward_dir;
    logic              no_frames;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [CountW-1:0] frame_count;
    logic              range_mode;
    logic              bounce_mode;
    logic              once_mode;
    logic [MaskW-1:0]  selection_mask;
  } cfg_t;

  typedef struct packed {
    logic [FrameW-1:0] frame_index;
    logic              play_forward;
    logic              running;
  } state_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [FrameW-1:0] lowest_set(input logic [MaskW-1:0] x);
    logic [MaskW-1:0]  one_hot;
    logic [FrameW-1:0] idx;
    one_hot = x & (~x + MaskW'(1));
    idx = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (one_hot[i]) begin
        idx = idx | FrameW'(i);
      end
    end
    return idx;
  endfunction

  // Index of the highest set bit, found as the lowest bit of the reversed word.
  function automatic logic [FrameW-1:0] highest_set(input logic [MaskW-1:0] x);
    logic [MaskW-1:0] rev;
    for (int i = 0; i < MaskW; i++) begin
      rev[i] = x[MaskW-1-i];
    end
    return FrameW'(MaskW - 1) - lowest_set(rev);
  endfunction

endpackage

[rtl/fps_channels.sv]
interface fps_cmd_if;
  logic         valid;
  logic         ready;
  fps_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fps_res_if;
  logic         valid;
  logic         ready;
  fps_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fps_cfg_if;
  logic            valid;
  logic            ready;
  fps_pkg::cfg_wr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/frame_playback_sequencer.sv]
// Frame playback sequencer.
// Commands arrive on cmd_i (tick, step forward, step back, go to frame, play,
// stop) and each produces exactly one result on res_o, carrying the current
// frame, whether a frame was shown, the playing flag, the direction and a
// flag for commands ignored because no frames are loaded.
// The five settings registers are written through cfg_i, which is always
// ready; they should only be changed while no command is in flight.
// A command is captured in an input register, then decoded against the
// sequencer state once the output register is free or being emptied, and its
// result is loaded into the output register, from which it transfers on res_o.
// One command is taken per cycle while the receiver does not stall: the state
// update is a single registered pass whose longest path is the next/previous
// selected-frame search over the 64-bit selection mask.
// When the receiver stalls, the result stays in the output register, the
// captured command waits in the input register, and cmd_i drops ready only
// once both are full.
// Reset clears the settings to zero, puts the sequencer on frame 0, playing
// forward but stopped, and empties both registers.
module frame_playback_sequencer (
  input  logic     clk_i,
  input  logic     rst_ni,
  fps_cmd_if.sink  cmd_i,
  fps_cfg_if.sink  cfg_i,
  fps_res_if.source res_o
);

  fps_pkg::cfg_t   cfg;
  fps_pkg::state_t state_q, state_d;
  fps_pkg::cmd_t   cmd_q;
  fps_pkg::res_t   res_d, res_q;
  logic            cmd_valid_q, res_valid_q;
  logic            cmd_take, cmd_adv;

  fps_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fps_next_state u_next_state (
    .cfg_i   (cfg),
    .state_i (state_q),
    .cmd_i   (cmd_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // The captured command moves on whenever the output register is free or
  // its result is being transferred in this cycle.
  assign cmd_adv     = cmd_valid_q && (!res_valid_q || res_o.ready);
  assign cmd_i.ready = !cmd_valid_q || cmd_adv;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '{frame_index: '0, play_forward: 1'b1, running: 1'b0};
    end else begin
      if (cmd_i.ready) begin
        cmd_valid_q <= cmd_i.valid;
      end
      if (cmd_adv) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      cmd_q <= cmd_i.data;
    end
    if (cmd_adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // A command ignored for lack of frames never shows one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.no_frames |-> !res_q.frame_shown)
    else $error("ignored command reported a shown frame");

  // A shown frame always lies within the loaded frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.frame_shown |->
      ({1'b0, res_q.current_frame} < cfg.frame_count))
    else $error("shown frame beyond the frame count");

  // A stop command always leaves the sequencer stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_adv && cmd_q.kind == fps_pkg::KindStop |=> !state_q.running)
    else $error("stop did not clear the playing flag");

  // The sequencer state only changes when a command is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_adv |=> $stable(state_q))
    else $error("state changed without a command");

endmodule

[rtl/fps_cfg_regs.sv]
module fps_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  fps_cfg_if.sink       cfg_i,
  output fps_pkg::cfg_t cfg_o
);

  fps_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        fps_pkg::RegFrameCount: cfg_d.frame_count = cfg_i.data.data[fps_pkg::CountW-1:0];
        fps_pkg::RegRangeMode:  cfg_d.range_mode = cfg_i.data.data[0];
        fps_pkg::RegBounceMode: cfg_d.bounce_mode = cfg_i.data.data[0];
        fps_pkg::RegOnceMode:   cfg_d.once_mode = cfg_i.data.data[0];
        fps_pkg::RegSelMask:    cfg_d.selection_mask = cfg_i.data.data[fps_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/fps_next_state.sv]
module fps_next_state (
  input  fps_pkg::cfg_t   cfg_i,
  input  fps_pkg::state_t state_i,
  input  fps_pkg::cmd_t   cmd_i,
  output fps_pkg::state_t state_o,
  output fps_pkg::res_t   res_o
);

  localparam int CountW = fps_pkg::CountW;
  localparam int FrameW = fps_pkg::FrameW;
  localparam int MaskW  = fps_pkg::MaskW;

  logic [CountW-1:0] n;
  logic [FrameW-1:0] n_m1;
  logic [MaskW-1:0]  lim, m, above, below;
  logic [FrameW-1:0] cur, lo, hi;
  logic [FrameW-1:0] next_f, prev_f, first_f, last_f, new_idx;
  logic              fwd, at_end, do_step, none, shown;

  // Effective frame count and the selection restricted to loaded frames.
  assign n    = (cfg_i.frame_count > CountW'(fps_pkg::MaxFrames)) ?
                CountW'(fps_pkg::MaxFrames) : cfg_i.frame_count;
  assign n_m1 = FrameW'(n - CountW'(1));
  assign lim  = (n >= CountW'(fps_pkg::MaxFrames)) ? '1 :
                ((MaskW'(1) << n) - MaskW'(1));
  assign m    = cfg_i.selection_mask & lim;
  assign cur  = state_i.frame_index;

  // Selected frames strictly after and strictly before the current one.
  assign above = m & ~((MaskW'(2) << cur) - MaskW'(1));
  assign below = m & ((MaskW'(1) << cur) - MaskW'(1));
  assign lo    = fps_pkg::lowest_set(m);
  assign hi    = fps_pkg::highest_set(m);

  always_comb begin
    first_f = '0;
    last_f  = n_m1;
    if (!cfg_i.range_mode) begin
      next_f = ((CountW'(cur) + CountW'(1)) >= n) ? '0 : cur + FrameW'(1);
      prev_f = (cur == '0 || CountW'(cur) > n) ? n_m1 : cur - FrameW'(1);
    end else if (m == '0) begin
      next_f = cur;
      prev_f = cur;
    end else begin
      next_f  = (above != '0) ? fps_pkg::lowest_set(above) : lo;
      prev_f  = (below != '0) ? fps_pkg::highest_set(below) : hi;
      first_f = lo;
      last_f  = hi;
    end
  end

  always_comb begin
    state_o = state_i;
    none    = 1'b0;
    shown   = 1'b0;
    do_step = 1'b0;
    fwd     = state_i.play_forward;

    if (cmd_i.kind <= fps_pkg::KindPlay && n == '0) begin
      none = 1'b1;
    end else begin
      case (cmd_i.kind)
        fps_pkg::KindTick: begin
          do_step = state_i.running;
        end
        fps_pkg::KindStepFwd: begin
          do_step = 1'b1;
          fwd     = 1'b1;
        end
        fps_pkg::KindStepBack: begin
          do_step = 1'b1;
          fwd     = 1'b0;
        end
        fps_pkg::KindGoto: begin
          if (CountW'(cmd_i.target_frame) < n) begin
            state_o.frame_index = cmd_i.target_frame;
            shown = 1'b1;
          end
        end
        fps_pkg::KindPlay: state_o.running = 1'b1;
        fps_pkg::KindStop: state_o.running = 1'b0;
        default: ;
      endcase
    end

    new_idx = fwd ? next_f : prev_f;
    if (fwd) begin
      at_end = (new_idx == n_m1) || (cfg_i.range_mode && new_idx == last_f);
    end else begin
      at_end = (new_idx == '0) || (cfg_i.range_mode && new_idx == first_f);
    end

    if (do_step) begin
      state_o.frame_index  = new_idx;
      state_o.play_forward = fwd;
      if (at_end && cfg_i.once_mode) begin
        state_o.running = 1'b0;
      end
      if (at_end && cfg_i.bounce_mode) begin
        state_o.play_forward = !fwd;
      end
      shown = CountW'(new_idx) < n;
    end
  end

  assign res_o.current_frame = state_o.frame_index;
  assign res_o.frame_shown   = shown;
  assign res_o.is_playing    = state_o.running;
  assign res_o.forward_dir   = state_o.play_forward;
  assign res_o.no_frames     = none;

endmodule
